@@ src/ihsp_pkg.sv @@
package ihsp_pkg;

	localparam int HEADER_BYTES = 30;
	localparam int COUNT_BITS   = 32;
	localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

	localparam logic [31:0] SIG_PNG  = 32'h89504E47;
	localparam logic [15:0] SIG_JPEG = 16'hFFD8;
	localparam logic [23:0] SIG_GIF  = 24'h474946;
	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WEBP = 32'h57454250;
	localparam logic [31:0] TAG_VP8  = 32'h56503820;
	localparam logic [31:0] TAG_VP8L = 32'h5650384C;

	localparam logic [7:0] MRK_PREFIX = 8'hFF;
	localparam logic [7:0] MRK_STUFF  = 8'h00;
	localparam logic [3:0] MRK_SOF_HI = 4'hC;
	localparam logic [7:0] MRK_DHT    = 8'hC4;
	localparam logic [7:0] MRK_JPG    = 8'hC8;

	localparam logic [13:0] VP8_DIM_MASK = 14'h3FFF;

	typedef enum logic [2:0] {
		FMT_NONE      = 3'd0,
		FMT_PNG       = 3'd1,
		FMT_JPEG      = 3'd2,
		FMT_GIF       = 3'd3,
		FMT_WEBP_VP8  = 3'd4,
		FMT_WEBP_VP8L = 3'd5
	} fmt_t;

	typedef struct packed {
		logic                  sof_seen;
		logic [COUNT_BITS-1:0] sof_start;
		logic [31:0]           dims;
	} jscan_t;

endpackage

@@ src/image_header_size_probe.sv @@
// Image header size probe: takes an image file one byte per transfer, with
// end_of_file marking the last byte, and after that byte delivers one result
// with the format (PNG, JPEG, GIF, WebP lossy/lossless) and width/height;
// all other bytes give no result and the block then starts a new file.
// One byte is taken every cycle, save while a last byte is held; a byte passes an
// input register and then a result register, so a result is offered once its last
// byte has left the input register.
// A held last byte waits only while the result register is still full.
module image_header_size_probe import ihsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  format_kind,
	output logic        size_valid,
	output logic [30:0] image_width,
	output logic [30:0] image_height
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eof_s1;
	logic                  step;

	logic [7:0]            hdr_q [HEADER_BYTES];
	logic [7:0]            hdr_n [HEADER_BYTES];
	logic [COUNT_BITS-1:0] count_q, count_n;
	logic                  hdr_wr;
	jscan_t                scan;

	logic                  out_valid_q;
	fmt_t                  kind_q, kind_d;
	logic                  ok_q, ok_d;
	logic [30:0]           wd_q, wd_d;
	logic [30:0]           ht_q, ht_d;

	logic [31:0]           png_w, png_h, vp8l_pk;
	logic [15:0]           jpg_w, jpg_h, gif_w, gif_h;
	logic [13:0]           vp8_w, vp8_h;
	logic [COUNT_BITS-1:0] sof_span;

	assign step     = valid_s1 && (!eof_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	assign hdr_wr  = count_q < COUNT_BITS'(HEADER_BYTES);
	assign count_n = (count_q != '1) ? count_q + 1'b1 : count_q;

	always_comb begin
		for (int k = 0; k < HEADER_BYTES; k++) begin
			hdr_n[k] = (hdr_wr && (count_q[HDR_IDX_W-1:0] == HDR_IDX_W'(k))) ?
				byte_s1 : hdr_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (step && hdr_wr) begin
			hdr_q[count_q[HDR_IDX_W-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= eof_s1 ? '0 : count_n;
		end
	end

	ihsp_jpeg_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.clear  (eof_s1),
		.data   (byte_s1),
		.idx    (count_q),
		.scan_d (scan)
	);

	assign png_w    = {hdr_n[16], hdr_n[17], hdr_n[18], hdr_n[19]};
	assign png_h    = {hdr_n[20], hdr_n[21], hdr_n[22], hdr_n[23]};
	assign jpg_h    = scan.dims[31:16];
	assign jpg_w    = scan.dims[15:0];
	assign gif_w    = {hdr_n[7], hdr_n[6]};
	assign gif_h    = {hdr_n[9], hdr_n[8]};
	assign vp8_w    = {hdr_n[27][5:0], hdr_n[26]} & VP8_DIM_MASK;
	assign vp8_h    = {hdr_n[29][5:0], hdr_n[28]} & VP8_DIM_MASK;
	assign vp8l_pk  = {hdr_n[24], hdr_n[23], hdr_n[22], hdr_n[21]};
	assign sof_span = count_n - scan.sof_start;

	always_comb begin
		kind_d = FMT_NONE;
		ok_d   = 1'b0;
		wd_d   = '0;
		ht_d   = '0;
		if (count_n >= COUNT_BITS'(24)
				&& {hdr_n[0], hdr_n[1], hdr_n[2], hdr_n[3]} == SIG_PNG) begin
			kind_d = FMT_PNG;
			ok_d   = (png_w != '0) && (png_h != '0) && !png_w[31] && !png_h[31];
			wd_d   = png_w[30:0];
			ht_d   = png_h[30:0];
		end else if (count_n >= COUNT_BITS'(4) && {hdr_n[0], hdr_n[1]} == SIG_JPEG) begin
			kind_d = FMT_JPEG;
			ok_d   = scan.sof_seen && (sof_span >= COUNT_BITS'(10))
				&& (jpg_w != '0) && (jpg_h != '0);
			wd_d   = {15'd0, jpg_w};
			ht_d   = {15'd0, jpg_h};
		end else if (count_n >= COUNT_BITS'(10)
				&& {hdr_n[0], hdr_n[1], hdr_n[2]} == SIG_GIF) begin
			kind_d = FMT_GIF;
			ok_d   = (gif_w != '0) && (gif_h != '0);
			wd_d   = {15'd0, gif_w};
			ht_d   = {15'd0, gif_h};
		end else if (count_n >= COUNT_BITS'(HEADER_BYTES)
				&& {hdr_n[0], hdr_n[1], hdr_n[2], hdr_n[3]} == TAG_RIFF
				&& {hdr_n[8], hdr_n[9], hdr_n[10], hdr_n[11]} == TAG_WEBP) begin
			if ({hdr_n[12], hdr_n[13], hdr_n[14], hdr_n[15]} == TAG_VP8) begin
				kind_d = FMT_WEBP_VP8;
				ok_d   = (vp8_w != '0) && (vp8_h != '0);
				wd_d   = {17'd0, vp8_w};
				ht_d   = {17'd0, vp8_h};
			end else if ({hdr_n[12], hdr_n[13], hdr_n[14], hdr_n[15]} == TAG_VP8L) begin
				kind_d = FMT_WEBP_VP8L;
				ok_d   = 1'b1;
				wd_d   = {16'd0, {1'b0, vp8l_pk[13:0]} + 15'd1};
				ht_d   = {16'd0, {1'b0, vp8l_pk[27:14]} + 15'd1};
			end
		end
		if (!ok_d) begin
			wd_d = '0;
			ht_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && eof_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && eof_s1) begin
			kind_q <= kind_d;
			ok_q   <= ok_d;
			wd_q   <= wd_d;
			ht_q   <= ht_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign format_kind  = kind_q;
	assign size_valid   = ok_q;
	assign image_width  = wd_q;
	assign image_height = ht_q;

endmodule

@@ src/ihsp_jpeg_scan.sv @@
module ihsp_jpeg_scan import ihsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  clear,
	input  logic [7:0]            data,
	input  logic [COUNT_BITS-1:0] idx,
	output jscan_t                scan_d
);

	typedef enum logic [2:0] {
		PH_PREFIX = 3'd0,
		PH_CODE   = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_SKIP   = 3'd4,
		PH_SOF    = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [15:0]           skip_q, skip_d;
	logic [7:0]            seg_hi_q, seg_hi_d;
	logic                  sof_seen_q, sof_seen_d;
	logic [COUNT_BITS-1:0] sof_start_q, sof_start_d;
	logic [31:0]           dims_q, dims_d;
	logic [15:0]           seg_len;
	logic [15:0]           sof_pos;
	logic                  is_sof;
	logic                  active;

	assign active  = step && (idx[COUNT_BITS-1:1] != '0);
	assign seg_len = {seg_hi_q, data};
	assign sof_pos = skip_q + 16'd1;
	assign is_sof  = (data[7:4] == MRK_SOF_HI) && (data != MRK_DHT) && (data != MRK_JPG);

	always_comb begin
		phase_d     = phase_q;
		skip_d      = skip_q;
		seg_hi_d    = seg_hi_q;
		sof_seen_d  = sof_seen_q;
		sof_start_d = sof_start_q;
		dims_d      = dims_q;
		if (active) begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (data == MRK_PREFIX) begin
						phase_d     = PH_CODE;
						sof_start_d = idx;
					end
				end
				PH_CODE: begin
					if (data == MRK_PREFIX) begin
						sof_start_d = idx;
					end else if (data == MRK_STUFF) begin
						phase_d = PH_PREFIX;
					end else if (is_sof) begin
						sof_seen_d = 1'b1;
						skip_d     = 16'd1;
						phase_d    = PH_SOF;
					end else begin
						phase_d = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					seg_hi_d = data;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (seg_len <= 16'd2) begin
						phase_d = PH_PREFIX;
					end else begin
						skip_d  = seg_len - 16'd2;
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (skip_q <= 16'd1) begin
						skip_d  = '0;
						phase_d = PH_PREFIX;
					end else begin
						skip_d = skip_q - 16'd1;
					end
				end
				PH_SOF: begin
					skip_d = sof_pos;
					if (sof_pos >= 16'd5) begin
						dims_d = {dims_q[23:0], data};
					end
					if (sof_pos >= 16'd8) begin
						phase_d = PH_DONE;
					end
				end
				PH_DONE: begin
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	assign scan_d = '{sof_seen: sof_seen_d, sof_start: sof_start_d, dims: dims_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREFIX;
			skip_q      <= '0;
			seg_hi_q    <= '0;
			sof_seen_q  <= 1'b0;
			sof_start_q <= '0;
			dims_q      <= '0;
		end else if (step) begin
			if (clear) begin
				phase_q     <= PH_PREFIX;
				skip_q      <= '0;
				seg_hi_q    <= '0;
				sof_seen_q  <= 1'b0;
				sof_start_q <= '0;
				dims_q      <= '0;
			end else begin
				phase_q     <= phase_d;
				skip_q      <= skip_d;
				seg_hi_q    <= seg_hi_d;
				sof_seen_q  <= sof_seen_d;
				sof_start_q <= sof_start_d;
				dims_q      <= dims_d;
			end
		end
	end

endmodule

@@ tb/size_probe_checker.sv @@
`timescale 1ns / 1ps
module size_probe_checker import ihsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  format_kind,
	input  logic        size_valid,
	input  logic [30:0] image_width,
	input  logic [30:0] image_height,
	output int          mismatches,
	output int          pending
);

	typedef enum logic [2:0] {
		SC_PREFIX,
		SC_CODE,
		SC_LEN_HI,
		SC_LEN_LO,
		SC_SKIP,
		SC_SOF,
		SC_DONE
	} marker_scan_t;

	typedef struct packed {
		fmt_t        kind;
		logic        ok;
		logic [30:0] width;
		logic [30:0] height;
	} image_size_t;

	logic [7:0]            hdr [HEADER_BYTES];
	logic [COUNT_BITS-1:0] nbytes;
	marker_scan_t          scan;
	logic [15:0]           skip_left;
	logic [15:0]           seg_len;
	logic                  sof_found;
	logic [COUNT_BITS-1:0] sof_pos;
	logic [31:0]           sof_dims;
	image_size_t           expected_sizes[$];

	function automatic void clear_file();
		foreach (hdr[i]) hdr[i] = 8'h00;
		nbytes    = '0;
		scan      = SC_PREFIX;
		skip_left = '0;
		seg_len   = '0;
		sof_found = 1'b0;
		sof_pos   = '0;
		sof_dims  = '0;
	endfunction

	// JPEG marker walk, one byte at a time from file offset 2 on
	function automatic void scan_marker(logic [COUNT_BITS-1:0] pos, logic [7:0] b);
		logic [15:0] span;
		case (scan)
			SC_PREFIX: begin
				if (b == MRK_PREFIX) begin
					scan    = SC_CODE;
					sof_pos = pos;
				end
			end
			SC_CODE: begin
				if (b == MRK_PREFIX) begin
					sof_pos = pos;
				end else if (b == MRK_STUFF) begin
					scan = SC_PREFIX;
				end else if (b[7:4] == MRK_SOF_HI && b != MRK_DHT && b != MRK_JPG) begin
					sof_found = 1'b1;
					skip_left = 16'd1;
					scan      = SC_SOF;
				end else begin
					scan = SC_LEN_HI;
				end
			end
			SC_LEN_HI: begin
				seg_len = {b, 8'h00};
				scan    = SC_LEN_LO;
			end
			SC_LEN_LO: begin
				span    = seg_len | {8'h00, b};
				seg_len = span;
				if (span <= 16'd2) begin
					scan = SC_PREFIX;
				end else begin
					skip_left = span - 16'd2;
					scan      = SC_SKIP;
				end
			end
			SC_SKIP: begin
				if (skip_left <= 16'd1) begin
					skip_left = '0;
					scan      = SC_PREFIX;
				end else begin
					skip_left = skip_left - 16'd1;
				end
			end
			SC_SOF: begin
				skip_left = skip_left + 16'd1;
				if (skip_left >= 16'd5) sof_dims = {sof_dims[23:0], b};
				if (skip_left >= 16'd8) scan = SC_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic image_size_t size_of_file();
		image_size_t r;
		logic [31:0] w, h, le;
		r = '0;
		w = '0;
		h = '0;
		if (nbytes >= 24 && {hdr[0], hdr[1], hdr[2], hdr[3]} == SIG_PNG) begin
			r.kind = FMT_PNG;
			w      = {hdr[16], hdr[17], hdr[18], hdr[19]};
			h      = {hdr[20], hdr[21], hdr[22], hdr[23]};
			r.ok   = w != 0 && h != 0 && !w[31] && !h[31];
		end else if (nbytes >= 4 && {hdr[0], hdr[1]} == SIG_JPEG) begin
			r.kind = FMT_JPEG;
			h      = {16'h0000, sof_dims[31:16]};
			w      = {16'h0000, sof_dims[15:0]};
			r.ok   = sof_found && (nbytes - sof_pos) >= 10 && w != 0 && h != 0;
		end else if (nbytes >= 10 && {hdr[0], hdr[1], hdr[2]} == SIG_GIF) begin
			r.kind = FMT_GIF;
			w      = {16'h0000, hdr[7], hdr[6]};
			h      = {16'h0000, hdr[9], hdr[8]};
			r.ok   = w != 0 && h != 0;
		end else if (nbytes >= 30 && {hdr[0], hdr[1], hdr[2], hdr[3]} == TAG_RIFF
				&& {hdr[8], hdr[9], hdr[10], hdr[11]} == TAG_WEBP) begin
			if ({hdr[12], hdr[13], hdr[14], hdr[15]} == TAG_VP8) begin
				r.kind = FMT_WEBP_VP8;
				w      = {16'h0000, hdr[27], hdr[26]} & {18'h0, VP8_DIM_MASK};
				h      = {16'h0000, hdr[29], hdr[28]} & {18'h0, VP8_DIM_MASK};
				r.ok   = w != 0 && h != 0;
			end else if ({hdr[12], hdr[13], hdr[14], hdr[15]} == TAG_VP8L) begin
				r.kind = FMT_WEBP_VP8L;
				le     = {hdr[24], hdr[23], hdr[22], hdr[21]};
				w      = 32'(le[13:0]) + 32'd1;
				h      = 32'(le[27:14]) + 32'd1;
				r.ok   = 1'b1;
			end
		end
		if (r.ok) begin
			r.width  = w[30:0];
			r.height = h[30:0];
		end
		return r;
	endfunction

	always @(posedge clk) begin : watch
		logic [COUNT_BITS-1:0] pos;
		image_size_t           want;
		if (!arst_n) begin
			clear_file();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sizes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d valid %0b width %0d height %0d",
							format_kind, size_valid, image_width, image_height);
				end else begin
					want = expected_sizes.pop_front();
					if (format_kind !== want.kind || size_valid !== want.ok ||
							image_width !== want.width || image_height !== want.height) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected kind %0d valid %0b width %0d ",
								"height %0d, got kind %0d valid %0b width %0d height %0d"},
								want.kind, want.ok, want.width, want.height,
								format_kind, size_valid, image_width, image_height);
					end
				end
			end
			if (in_valid && in_ready) begin
				pos = nbytes;
				if (nbytes < HEADER_BYTES) hdr[nbytes[4:0]] = data_byte;
				if (nbytes != '1) nbytes = nbytes + 1'b1;
				if (pos >= 2) scan_marker(pos, data_byte);
				if (end_of_file) begin
					expected_sizes = {expected_sizes, size_of_file()};
					clear_file();
				end
			end
			pending = expected_sizes.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import ihsp_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [7:0]  data_byte   = 8'h00;
	logic        end_of_file = 1'b0;
	logic        out_ready   = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [2:0]  format_kind;
	logic        size_valid;
	logic [30:0] image_width;
	logic [30:0] image_height;

	int mismatches;
	int pending;

	logic [7:0] file_bytes[$];
	int         burst_left = 0;
	int         bytes_sent = 0;
	int         files_sent = 0;
	int         rx_mode    = 0;
	int         rx_left    = 0;
	int         rx_tick    = 0;

	image_header_size_probe u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.format_kind  (format_kind),
		.size_valid   (size_valid),
		.image_width  (image_width),
		.image_height (image_height)
	);

	size_probe_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.format_kind  (format_kind),
		.size_valid   (size_valid),
		.image_width  (image_width),
		.image_height (image_height),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// receiver: modes of always ready, coin flip, mostly stalled, fixed pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(8, 60);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: out_ready <= (rx_tick % 5) < 2;
		endcase
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
			else idle++;
		end
		$display("status: fail");
		$finish;
	end

	function automatic void add_byte(logic [7:0] b);
		file_bytes = {file_bytes, b};
	endfunction

	function automatic void add_rand(int n);
		repeat (n) add_byte(8'($urandom));
	endfunction

	function automatic void add_be32(logic [31:0] v);
		add_byte(v[31:24]);
		add_byte(v[23:16]);
		add_byte(v[15:8]);
		add_byte(v[7:0]);
	endfunction

	function automatic void add_le16(logic [15:0] v);
		add_byte(v[7:0]);
		add_byte(v[15:8]);
	endfunction

	function automatic logic [31:0] rand_word32();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_dim16();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void build_png(logic [31:0] w, logic [31:0] h);
		add_be32(SIG_PNG);
		add_rand(12);
		add_be32(w);
		add_be32(h);
	endfunction

	function automatic void build_gif(logic [15:0] w, logic [15:0] h);
		add_byte(SIG_GIF[23:16]);
		add_byte(SIG_GIF[15:8]);
		add_byte(SIG_GIF[7:0]);
		add_rand(3);
		add_le16(w);
		add_le16(h);
	endfunction

	function automatic void build_vp8(logic [15:0] w, logic [15:0] h);
		add_be32(TAG_RIFF);
		add_rand(4);
		add_be32(TAG_WEBP);
		add_be32(TAG_VP8);
		add_rand(10);
		add_le16(w);
		add_le16(h);
	endfunction

	function automatic void build_vp8l(logic [31:0] packed_size);
		add_be32(TAG_RIFF);
		add_rand(4);
		add_be32(TAG_WEBP);
		add_be32(TAG_VP8L);
		add_rand(5);
		add_be32(packed_size);
		add_rand(5);
	endfunction

	// SOI, a few random segments, fill and stuffed bytes, then optionally an SOF
	function automatic void build_jpeg(logic with_sof, logic [15:0] h, logic [15:0] w);
		logic [7:0] code;
		int         len;
		add_byte(SIG_JPEG[15:8]);
		add_byte(SIG_JPEG[7:0]);
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 5))
				0: add_byte(MRK_PREFIX);
				1: begin
					add_byte(MRK_PREFIX);
					add_byte(MRK_STUFF);
				end
				2: add_byte(8'($urandom_range(0, 254)));
				default: begin
					code = 8'($urandom_range(1, 254));
					if (code[7:4] == MRK_SOF_HI && code != MRK_JPG) code = MRK_DHT;
					case ($urandom_range(0, 5))
						0: len = $urandom_range(0, 1);
						1: len = $urandom_range(2, 300);
						default: len = $urandom_range(2, 12);
					endcase
					add_byte(MRK_PREFIX);
					add_byte(code);
					add_byte(8'(len >> 8));
					add_byte(8'(len));
					add_rand(len < 2 ? 0 : len - 2);
				end
			endcase
		end
		if (with_sof) begin
			do code = {MRK_SOF_HI, 4'($urandom_range(0, 15))};
			while (code == MRK_DHT || code == MRK_JPG);
			add_byte(MRK_PREFIX);
			add_byte(code);
			add_byte(8'h00);
			add_byte(8'h11);
			add_byte(8'h08);
			add_byte(h[15:8]);
			add_byte(h[7:0]);
			add_byte(w[15:8]);
			add_byte(w[7:0]);
			add_byte(8'h03);
			add_rand($urandom_range(0, 9));
		end
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last);
		logic acc;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_file <= last;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
		bytes_sent++;
	endtask

	// keep = 0 sends the whole file, otherwise only its first keep bytes
	task automatic send_file(input int keep);
		if (keep <= 0 || keep > file_bytes.size()) keep = file_bytes.size();
		for (int i = 0; i < keep; i++) push_byte(file_bytes[i], i == keep - 1);
		file_bytes.delete();
		files_sent++;
	endtask

	initial begin
		int rand_bytes0;
		int rand_files0;
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		build_png(32'd1, 32'd1);
		send_file(0);
		build_png(32'h7FFF_FFFF, 32'h8000_0000);
		add_rand(3);
		send_file(0);
		build_png(32'd640, 32'd480);
		send_file(23);
		build_gif(16'hFFFF, 16'hFFFF);
		send_file(0);
		build_gif(16'h0000, 16'h0005);
		send_file(0);
		build_vp8(16'hFFFF, 16'h0001);
		send_file(0);
		build_vp8l(32'hFFFF_FFFF);
		send_file(0);
		build_vp8l(32'h0000_0000);
		send_file(29);
		build_vp8(16'd5, 16'd5);
		file_bytes[15] = "X";
		send_file(0);
		// zero length segment, stuffed byte, fill byte, then SOF0 ending at its tenth byte
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF,
			8'hC0, 8'h00, 8'h11, 8'h08, 8'h12, 8'h34, 8'h56, 8'h78, 8'h03};
		send_file(0);
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF,
			8'hC0, 8'h00, 8'h11, 8'h08, 8'h12, 8'h34, 8'h56, 8'h78, 8'h03};
		send_file(18);
		// DHT and JPG markers are plain segments, SOF15 follows
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hC4, 8'h00, 8'h04, 8'hAA, 8'hBB, 8'hFF, 8'hC8,
			8'h00, 8'h02, 8'hFF, 8'hCF, 8'h00, 8'h0B, 8'h08, 8'h00, 8'h20, 8'h00, 8'h40,
			8'h01};
		send_file(0);
		// length one segment, SOF2 with zero height
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hDB, 8'h00, 8'h01, 8'hFF, 8'hC2, 8'h00, 8'h0B,
			8'h08, 8'h00, 8'h00, 8'h00, 8'h10, 8'h01};
		send_file(0);
		build_jpeg(1'b0, 16'd0, 16'd0);
		send_file(0);
		file_bytes = {8'hFF, 8'hD8, 8'h00};
		send_file(0);
		file_bytes = {8'h00};
		send_file(0);

		rand_bytes0 = bytes_sent;
		rand_files0 = files_sent;
		while (bytes_sent - rand_bytes0 < 500 || files_sent - rand_files0 < 12) begin
			case ($urandom_range(0, 9))
				0, 1: build_png(rand_word32(), rand_word32());
				2, 3, 4: build_jpeg($urandom_range(0, 7) != 0, rand_dim16(), rand_dim16());
				5: build_gif(rand_dim16(), rand_dim16());
				6: build_vp8(rand_dim16(), rand_dim16());
				7: build_vp8l(rand_word32());
				8: begin
					case ($urandom_range(0, 3))
						0: build_png(rand_word32(), rand_word32());
						1: build_gif(rand_dim16(), rand_dim16());
						2: build_vp8(rand_dim16(), rand_dim16());
						default: build_vp8l(rand_word32());
					endcase
					k = $urandom_range(0, 15);
					file_bytes[k] = file_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
				end
				default: add_rand($urandom_range(1, 40));
			endcase
			add_rand($urandom_range(0, 6));
			if ($urandom_range(0, 4) == 0) send_file($urandom_range(1, file_bytes.size()));
			else send_file(0);
		end
		in_valid <= 1'b0;

		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
